### hw/rtl/evm_alu_pkg.sv
// Shared types for the 256-bit EVM word ALU: operation codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none
package evm_alu_pkg;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
      OP_MOD  = 5'd4,  OP_AND  = 5'd5,  OP_OR   = 5'd6,  OP_XOR  = 5'd7,
      OP_NOT  = 5'd8,  OP_GT   = 5'd9,  OP_EQ   = 5'd10, OP_LT   = 5'd11,
      OP_EXP  = 5'd12, OP_SDIV = 5'd13, OP_SMOD = 5'd14, OP_SGT  = 5'd15,
      OP_SLT  = 5'd16, OP_SHL  = 5'd17, OP_SHR  = 5'd18, OP_SAR  = 5'd19
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_MUL, ST_DIV, ST_EXP_TEST, ST_EXP_RMUL,
      ST_EXP_SQR, ST_OUT
   } state_type;

   // multiplier operand pairs
   typedef enum logic [1:0] {
      MSEL_AB, MSEL_RP, MSEL_PP
   } msel_type;

   typedef struct packed {
      logic     load;       // capture request payload
      logic     simple_wr;  // write combinational result
      logic     mul_start;
      msel_type mul_sel;
      logic     mul_to_res;
      logic     mul_to_r;
      logic     mul_to_p;   // also shifts exponent
      logic     div_start;
      logic     div_wr;
      logic     exp_init;
      logic     exp_wr;     // result = running product
   } cmd_type;

   typedef struct packed {
      logic [4:0] op;
      logic       mul_done;
      logic       div_done;
      logic       e_zero;
      logic       e_lsb;
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/evm_alu_if.sv
// Valid/ready stream interfaces for request and response channels.
// No dependencies.
`default_nettype none
interface evm_alu_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  op;
   logic [63:0] operand_a_w0, operand_a_w1, operand_a_w2, operand_a_w3;
   logic [63:0] operand_b_w0, operand_b_w1, operand_b_w2, operand_b_w3;
   modport source (output valid, op, operand_a_w0, operand_a_w1, operand_a_w2,
                   operand_a_w3, operand_b_w0, operand_b_w1, operand_b_w2,
                   operand_b_w3, input ready);
   modport sink (input valid, op, operand_a_w0, operand_a_w1, operand_a_w2,
                 operand_a_w3, operand_b_w0, operand_b_w1, operand_b_w2,
                 operand_b_w3, output ready);
endinterface

interface evm_alu_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_w0, result_w1, result_w2, result_w3;
   modport source (output valid, result_w0, result_w1, result_w2, result_w3,
                   input ready);
   modport sink (input valid, result_w0, result_w1, result_w2, result_w3,
                 output ready);
endinterface
`default_nettype wire

### hw/rtl/evm_alu_mul.sv
// 256x256 low-half multiplier, one 32x32 partial product per cycle.
// Depends on nothing; used by evm_alu_dp.
`default_nettype none
module evm_alu_mul (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [255:0] x,
   input  wire logic [255:0] y,
   output logic              done,
   output logic [255:0]      prod
);
   logic [255:0] x_ff, y_ff, acc_ff, acc_in;
   logic [2:0]   i_ff, j_ff, sh_ff;
   logic         issue_ff, pp_vld_ff, pp_last_ff, done_ff;
   logic [63:0]  pp_ff;
   logic [2:0]   ij;
   logic         row_end;

   assign ij      = i_ff + j_ff;
   assign row_end = (ij == 3'd7);
   assign acc_in  = acc_ff + (256'(pp_ff) << {sh_ff, 5'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= 1'b0;
         pp_vld_ff  <= 1'b0;
         pp_last_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (start) begin
         issue_ff   <= 1'b1;
         pp_vld_ff  <= 1'b0;
         pp_last_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         pp_vld_ff  <= issue_ff;
         pp_last_ff <= issue_ff && row_end && (i_ff == 3'd7);
         done_ff    <= pp_vld_ff && pp_last_ff;
         if (issue_ff && row_end && (i_ff == 3'd7)) issue_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         y_ff   <= y;
         acc_ff <= '0;
         i_ff   <= '0;
         j_ff   <= '0;
      end else begin
         if (issue_ff) begin
            pp_ff <= 64'(x_ff[{i_ff, 5'b0} +: 32]) * 64'(y_ff[{j_ff, 5'b0} +: 32]);
            sh_ff <= ij;
            if (row_end) begin
               i_ff <= i_ff + 3'd1;
               j_ff <= '0;
            end else begin
               j_ff <= j_ff + 3'd1;
            end
         end
         if (pp_vld_ff) acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

### hw/rtl/evm_alu_div.sv
// 256-bit restoring divider, one quotient bit per cycle.
// Depends on nothing; used by evm_alu_dp.
`default_nettype none
module evm_alu_div (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [255:0] x,
   input  wire logic [255:0] y,
   output logic              done,
   output logic [255:0]      quo,
   output logic [255:0]      rem
);
   logic [255:0] n_ff, d_ff, rem_ff;
   logic [7:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [256:0] rem_sh;
   logic [257:0] diff;
   logic         ge;

   assign rem_sh = {rem_ff, n_ff[255]};
   assign diff   = {1'b0, rem_sh} - {2'b0, d_ff};
   assign ge     = ~diff[257];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 8'd255);
         if (start) busy_ff <= 1'b1;
         else if (cnt_ff == 8'd255) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= x;
         d_ff   <= y;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[255:0] : rem_sh[255:0];
         n_ff   <= {n_ff[254:0], ge};
         cnt_ff <= cnt_ff + 8'd1;
      end
   end

   assign done = done_ff;
   assign quo  = n_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

### hw/rtl/evm_alu_dp.sv
// Datapath: operand and result registers, combinational ops, exponent
// registers, multiplier and divider. Depends on evm_alu_pkg, mul, div.
`default_nettype none
module evm_alu_dp
   import evm_alu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output status_type        status,
   input  wire logic [4:0]   in_op,
   input  wire logic [255:0] in_a,
   input  wire logic [255:0] in_b,
   output logic [255:0]      result
);
   logic [4:0]   op_ff;
   logic [255:0] a_ff, b_ff, res_ff, r_ff, p_ff, e_ff;
   logic [255:0] simple, mx, my, prod, quo, rem, dx, dy, dsel;
   logic         mul_done, div_done, na, nb, sgn, neg;

   assign na  = a_ff[255];
   assign nb  = b_ff[255];
   assign sgn = (op_ff == OP_SDIV) || (op_ff == OP_SMOD);

   always_comb begin
      simple = '0;
      case (op_type'(op_ff))
         OP_ADD: simple = a_ff + b_ff;
         OP_SUB: simple = a_ff - b_ff;
         OP_AND: simple = a_ff & b_ff;
         OP_OR:  simple = a_ff | b_ff;
         OP_XOR: simple = a_ff ^ b_ff;
         OP_NOT: simple = ~a_ff;
         OP_GT:  simple = 256'(a_ff > b_ff);
         OP_EQ:  simple = 256'(a_ff == b_ff);
         OP_LT:  simple = 256'(a_ff < b_ff);
         OP_SGT: simple = 256'($signed(a_ff) > $signed(b_ff));
         OP_SLT: simple = 256'($signed(a_ff) < $signed(b_ff));
         OP_SHL: simple = (a_ff > 256'd255) ? '0 : b_ff << a_ff[7:0];
         OP_SHR: simple = (a_ff > 256'd255) ? '0 : b_ff >> a_ff[7:0];
         OP_SAR: simple = (a_ff > 256'd255) ? {256{nb}}
                                            : 256'($signed(b_ff) >>> a_ff[7:0]);
         default: simple = '0;
      endcase
   end

   always_comb begin
      case (cmd.mul_sel)
         MSEL_RP: begin mx = r_ff; my = p_ff; end
         MSEL_PP: begin mx = p_ff; my = p_ff; end
         default: begin mx = a_ff; my = b_ff; end
      endcase
   end

   assign dx = (sgn && na) ? -a_ff : a_ff;
   assign dy = (sgn && nb) ? -b_ff : b_ff;

   always_comb begin
      if ((op_ff == OP_DIV) || (op_ff == OP_SDIV)) begin
         dsel = quo;
         neg  = (op_ff == OP_SDIV) && (na != nb);
      end else begin
         dsel = rem;
         neg  = (op_ff == OP_SMOD) && na;
      end
   end

   evm_alu_mul u_mul (
      .clock, .reset, .start(cmd.mul_start), .x(mx), .y(my),
      .done(mul_done), .prod
   );

   evm_alu_div u_div (
      .clock, .reset, .start(cmd.div_start), .x(dx), .y(dy),
      .done(div_done), .quo, .rem
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= '0;
      end else if (cmd.load) begin
         op_ff <= in_op;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= in_a;
         b_ff <= in_b;
      end
      if (cmd.simple_wr) res_ff <= simple;
      if (cmd.mul_to_res) res_ff <= prod;
      if (cmd.div_wr) res_ff <= (b_ff == '0) ? '0 : (neg ? -dsel : dsel);
      if (cmd.exp_wr) res_ff <= r_ff;
      if (cmd.exp_init) begin
         r_ff <= 256'd1;
         p_ff <= a_ff;
         e_ff <= b_ff;
      end
      if (cmd.mul_to_r) r_ff <= prod;
      if (cmd.mul_to_p) begin
         p_ff <= prod;
         e_ff <= {1'b0, e_ff[255:1]};
      end
   end

   assign status.op       = op_ff;
   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.e_zero   = (e_ff == '0);
   assign status.e_lsb    = e_ff[0];
   assign result          = res_ff;
endmodule
`default_nettype wire

### hw/rtl/evm_alu_ctrl.sv
// Controller state machine: sequences accept, dispatch, multi-cycle
// units and response. Depends on evm_alu_pkg.
`default_nettype none
module evm_alu_ctrl
   import evm_alu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic is_mul, is_div, is_exp;

   assign is_mul = (status.op == OP_MUL);
   assign is_exp = (status.op == OP_EXP);
   assign is_div = (status.op == OP_DIV) || (status.op == OP_MOD) ||
                   (status.op == OP_SDIV) || (status.op == OP_SMOD);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (is_mul)      state_in = ST_MUL;
            else if (is_div) state_in = ST_DIV;
            else if (is_exp) state_in = ST_EXP_TEST;
            else             state_in = ST_OUT;
         end
         ST_MUL:      if (status.mul_done) state_in = ST_OUT;
         ST_DIV:      if (status.div_done) state_in = ST_OUT;
         ST_EXP_TEST: begin
            if (status.e_zero)     state_in = ST_OUT;
            else if (status.e_lsb) state_in = ST_EXP_RMUL;
            else                   state_in = ST_EXP_SQR;
         end
         ST_EXP_RMUL: if (status.mul_done) state_in = ST_EXP_SQR;
         ST_EXP_SQR:  if (status.mul_done) state_in = ST_EXP_TEST;
         ST_OUT:      if (rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.mul_sel = MSEL_AB;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DISPATCH: begin
            cmd.simple_wr = !(is_mul || is_div || is_exp);
            cmd.mul_start = is_mul;
            cmd.div_start = is_div;
            cmd.exp_init  = is_exp;
         end
         ST_MUL: cmd.mul_to_res = status.mul_done;
         ST_DIV: cmd.div_wr     = status.div_done;
         ST_EXP_TEST: begin
            cmd.exp_wr    = status.e_zero;
            cmd.mul_start = !status.e_zero;
            cmd.mul_sel   = status.e_lsb ? MSEL_RP : MSEL_PP;
         end
         ST_EXP_RMUL: begin
            cmd.mul_to_r  = status.mul_done;
            cmd.mul_start = status.mul_done;
            cmd.mul_sel   = MSEL_PP;
         end
         ST_EXP_SQR: cmd.mul_to_p = status.mul_done;
         ST_OUT:     rsp_valid    = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

### hw/rtl/evm_word_alu_256_unit.sv
// Top level of the 256-bit EVM word ALU.
// Depends on evm_alu_pkg, evm_alu_if, evm_alu_ctrl and evm_alu_dp.
//
// Usage:
//  - req channel: op plus operands a and b as four 64-bit limbs each,
//    limb 0 lowest. A transfer happens when valid and ready are both high.
//  - rsp channel: one 256-bit result per request, four limbs.
//  - One item at a time: req.ready is high only while the unit is idle.
//  - Work from request transfer to rsp.valid, by operation:
//      add/sub/logic/compare/shift: combinational, written to the result register
//      mul: 36 32x32 partial products, one per cycle
//      div/mod/sdiv/smod: 256 quotient bits, one quotient bit per cycle
//      exp: one square per exponent bit up to its highest set bit plus one
//           multiply per set bit, all on the shared multiplier.
//  - When the receiver stalls, the result is held in its register with
//    rsp.valid high until the transfer; no new request is taken meanwhile.
//  - Reset (synchronous, active high) returns the controller to idle and
//    drops any item in flight.
`default_nettype none
module evm_word_alu_256_unit
   import evm_alu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   evm_alu_req_if.sink   req,
   evm_alu_rsp_if.source rsp
);
   cmd_type      cmd;
   status_type   status;
   logic [255:0] result;

   // controller only sees handshake and status
   evm_alu_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status, .cmd
   );

   evm_alu_dp u_dp (
      .clock, .reset, .cmd, .status,
      .in_op(req.op),
      .in_a({req.operand_a_w3, req.operand_a_w2, req.operand_a_w1, req.operand_a_w0}),
      .in_b({req.operand_b_w3, req.operand_b_w2, req.operand_b_w1, req.operand_b_w0}),
      .result
   );

   assign rsp.result_w0 = result[63:0];
   assign rsp.result_w1 = result[127:64];
   assign rsp.result_w2 = result[191:128];
   assign rsp.result_w3 = result[255:192];
endmodule
`default_nettype wire
